// File: design/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, sizes and codes for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    // Storage size and key width.
    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;

    // Entry address, entry count and child index widths.
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = ADDR_W + 2;

    // Command codes carried on the request side.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Ordering modes.
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef logic signed [KEY_WIDTH-1:0] key_t;

    // One result as it leaves the sequencer.
    typedef struct packed {
        status_t          status;
        logic             heap_empty;
        logic [CNT_W-1:0] entry_count;
        key_t             root_value;
    } result_t;

    // True when key a belongs strictly nearer the root than key b.
    function automatic logic outranks(input logic mode, input key_t a, input key_t b);
        logic res;
        if (mode == MODE_MIN)
        begin
            res = (a < b);
        end
        else
        begin
            res = (a > b);
        end
        return res;
    endfunction

endpackage

// File: design/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Binary heap priority queue of signed keys held in a single RAM.
// ----------------------------------------------------------------------------
// Takes one request at a time and returns one result for each. An insert
// climbs level by level towards the root, and a delete sinks level by level
// towards a leaf. A dropped insert, an ignored delete or a delete that
// empties the heap is answered without touching the key store. The next
// request is taken once the previous result has moved into the output
// register. Each level is walked through the single read port of the key
// store: each level needs a read, a compare and a write back, and a delete
// reads two children per level. The ordering mode is written through
// cfg_wr_en and only takes effect while the heap is empty.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue
    import bhpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // order_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] key_value
    input  logic [0:0]  s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [31:0] root_value, [38:32] entry_count,
                                        // [39] heap_empty, [41:40] status, rest zero
);

    logic        res_valid;
    logic        res_ready;
    result_t     res_data;
    logic        m_valid_reg;
    logic [47:0] m_data_reg;

    bhpq_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (s_axis_tvalid),
        .cmd_ready   (s_axis_tready),
        .cmd_code    (s_axis_tuser[0]),
        .cmd_key     (key_t'(s_axis_tdata)),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    // Output register takes a new result when empty or being drained.
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= 48'({res_data.status, res_data.heap_empty,
                               res_data.entry_count, res_data.root_value});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// File: design/bhpq_ram.sv
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bhpq_seq.sv
// ----------------------------------------------------------------------------
// bhpq_seq
// Heap sequencer: takes one command at a time, walks the key store in the
// RAM level by level and hands one result to the output stage.
// ----------------------------------------------------------------------------
module bhpq_seq
    import bhpq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  logic    cmd_code,
    input  key_t    cmd_key,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_RD  = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_DN_LD  = 7'b0001000,
        S_DN_RD1 = 7'b0010000,
        S_DN_RD2 = 7'b0100000,
        S_DN_CMP = 7'b1000000
    } state_t;

    // S_DONE folded into a flag so the result waits without blocking the FSM code.
    state_t           state_reg, state_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             mode_reg;
    status_t          status_reg, status_next;
    key_t             root_reg;
    key_t             key_reg, key_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    key_t             best_val_reg, best_val_next;
    logic             best_first_reg, best_first_next;
    logic             second_ok_reg, second_ok_next;

    // RAM port controls.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    key_t              ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata_raw;
    key_t              ram_rdata;

    // Index arithmetic around the current position.
    logic [ADDR_W-1:0]  parent_idx;
    logic [CHILD_W-1:0] first_idx;
    logic [CHILD_W-1:0] second_idx;
    logic [CHILD_W-1:0] fill_ext;
    logic [CNT_W-1:0]   fill_dec;
    logic               accept;

    assign parent_idx = (pos_reg - ADDR_W'(1)) >> 1;
    assign first_idx  = {1'b0, pos_reg, 1'b1};
    assign second_idx = first_idx + CHILD_W'(1);
    assign fill_ext   = CHILD_W'(fill_reg);
    assign fill_dec   = fill_reg - CNT_W'(1);
    assign ram_rdata  = key_t'(ram_rdata_raw);

    assign cmd_ready = (state_reg == S_IDLE) && !done_reg;
    assign accept    = cmd_valid && cmd_ready;

    // Key store.
    bhpq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata_raw)
    );

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        done_next       = done_reg;
        fill_next       = fill_reg;
        status_next     = status_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        best_val_next   = best_val_reg;
        best_first_next = best_first_reg;
        second_ok_next  = second_ok_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = key_reg;
        ram_re          = 1'b0;
        ram_raddr       = parent_idx;

        if (done_reg && res_ready)
        begin
            done_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_DONE;
                    if (cmd_code == CMD_INSERT)
                    begin
                        if (fill_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            key_next   = cmd_key;
                            pos_next   = fill_reg[ADDR_W-1:0];
                            fill_next  = fill_reg + CNT_W'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            fill_next = fill_dec;
                            if (fill_dec == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                // Fetch the last entry; it becomes the new root.
                                ram_re     = 1'b1;
                                ram_raddr  = fill_dec[ADDR_W-1:0];
                                state_next = S_DN_LD;
                            end
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                // Parent moves down into the hole, or the new key settles here.
                ram_we = 1'b1;
                if (outranks(mode_reg, key_reg, ram_rdata))
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DN_LD:
            begin
                key_next   = ram_rdata;
                pos_next   = '0;
                state_next = S_DN_RD1;
            end

            S_DN_RD1:
            begin
                if (first_idx >= fill_ext)
                begin
                    ram_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = first_idx[ADDR_W-1:0];
                    state_next = S_DN_RD2;
                end
            end

            S_DN_RD2:
            begin
                // First child against the carried key.
                if (outranks(mode_reg, ram_rdata, key_reg))
                begin
                    best_val_next   = ram_rdata;
                    best_first_next = 1'b1;
                end
                else
                begin
                    best_val_next   = key_reg;
                    best_first_next = 1'b0;
                end
                second_ok_next = (second_idx < fill_ext);
                if (second_idx < fill_ext)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = second_idx[ADDR_W-1:0];
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                // Second child against the better of key and first child.
                ram_we = 1'b1;
                if (second_ok_reg && outranks(mode_reg, ram_rdata, best_val_reg))
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = second_idx[ADDR_W-1:0];
                    state_next = S_DN_RD1;
                end
                else if (best_first_reg)
                begin
                    ram_wdata  = best_val_reg;
                    pos_next   = first_idx[ADDR_W-1:0];
                    state_next = S_DN_RD1;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            fill_reg   <= '0;
            mode_reg   <= MODE_MAX;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            fill_reg   <= fill_next;
            status_reg <= status_next;
            // The ordering mode only changes while the heap is empty.
            if (cfg_wr_en && (fill_reg == '0))
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        best_val_reg   <= best_val_next;
        best_first_reg <= best_first_next;
        second_ok_reg  <= second_ok_next;
        // Shadow copy of the root entry.
        if (ram_we && (ram_waddr == '0))
        begin
            root_reg <= ram_wdata;
        end
    end

    // Result towards the output stage.
    assign res_valid              = done_reg;
    assign res_data.root_value    = (fill_reg == '0) ? key_t'(0) : root_reg;
    assign res_data.entry_count   = fill_reg;
    assign res_data.heap_empty    = (fill_reg == '0);
    assign res_data.status        = status_reg;

endmodule
